// ===== rtl/cbtd_pkg.sv =====
// Shared types and constants for the compressed block texture decoder.
// No dependencies; imported by every module of the block.
package cbtd_pkg;

	// Field widths
	localparam int COLOR_W = 16;
	localparam int INDEX_W = 32;
	localparam int COORD_W = 10;
	localparam int DIM_W   = 11;
	localparam int TEXEL_W = 32;
	localparam int ROW_W   = 2;
	localparam int LANES   = 4;

	// Defaults
	localparam int                 MAX_DIMENSION_DEF = 1024;
	localparam logic [DIM_W-1:0]   DIM_RESET         = 11'd1024;
	localparam logic [ROW_W-1:0]   ROW_LAST          = 2'd3;
	localparam int                 QUEUE_DEPTH       = 2;

	// Channel masks and alpha codes
	localparam logic [4:0] MASK5        = 5'h1F;
	localparam logic [5:0] MASK6        = 6'h3F;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	// One classified subblock, as it waits between front and back
	typedef struct packed {
		logic [LANES-1:0][TEXEL_W-1:0] pal;
		logic [INDEX_W-1:0]            idx;
		logic [COORD_W-1:0]            ox;
		logic [COORD_W-1:0]            oy;
	} cbtd_entry_t;

	// Handshake between neighbors
	typedef struct packed {
		logic valid;
		logic ready;
	} cbtd_hs_t;

endpackage

// ===== rtl/cbtd_front.sv =====
// Front end: accepts a subblock beat, registers it, classifies the endpoints
// and builds the four-color palette. Depends on cbtd_pkg.
module cbtd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cbtd_pkg::COLOR_W-1:0]   color_first,
	input  logic [cbtd_pkg::COLOR_W-1:0]   color_second,
	input  logic [cbtd_pkg::INDEX_W-1:0]   index_bits,
	input  logic [cbtd_pkg::COORD_W-1:0]   origin_x,
	input  logic [cbtd_pkg::COORD_W-1:0]   origin_y,
	output logic                           push_valid,
	input  logic                           push_ready,
	output cbtd_pkg::cbtd_entry_t          push_data
);
	import cbtd_pkg::*;

	logic               v_s1;
	logic [COLOR_W-1:0] c0_s1;
	logic [COLOR_W-1:0] c1_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [COORD_W-1:0] ox_s1;
	logic [COORD_W-1:0] oy_s1;

	function automatic logic [7:0] widen5(input logic [4:0] n);
		return {n & MASK5, n[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] n);
		return {n & MASK6, n[5:4]};
	endfunction

	// (3a + 5b) >> 3, built from shifts and adds
	function automatic logic [7:0] blend38(input logic [7:0] a, input logic [7:0] b);
		logic [10:0] s;
		s = ({3'b0, a} << 1) + {3'b0, a} + ({3'b0, b} << 2) + {3'b0, b};
		return s[10:3];
	endfunction

	function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	assign in_ready   = !v_s1 || push_ready;
	assign push_valid = v_s1;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			c0_s1  <= color_first;
			c1_s1  <= color_second;
			idx_s1 <= index_bits;
			ox_s1  <= origin_x;
			oy_s1  <= origin_y;
		end
	end

	// Palette: gradient mode when first endpoint is larger, else halfway mode
	always_comb begin
		logic [7:0] r0, g0, b0, r1, g1, b1;
		logic [7:0] hr, hg, hb;
		r0 = widen5(c0_s1[15:11]);
		g0 = widen6(c0_s1[10:5]);
		b0 = widen5(c0_s1[4:0]);
		r1 = widen5(c1_s1[15:11]);
		g1 = widen6(c1_s1[10:5]);
		b1 = widen5(c1_s1[4:0]);
		hr = half(r0, r1);
		hg = half(g0, g1);
		hb = half(b0, b1);
		push_data.pal[0] = {ALPHA_OPAQUE, b0, g0, r0};
		push_data.pal[1] = {ALPHA_OPAQUE, b1, g1, r1};
		if (c0_s1 > c1_s1) begin
			push_data.pal[2] = {ALPHA_OPAQUE, blend38(b1, b0), blend38(g1, g0),
				blend38(r1, r0)};
			push_data.pal[3] = {ALPHA_OPAQUE, blend38(b0, b1), blend38(g0, g1),
				blend38(r0, r1)};
		end else begin
			push_data.pal[2] = {ALPHA_OPAQUE, hb, hg, hr};
			push_data.pal[3] = {ALPHA_CLEAR, hb, hg, hr};
		end
		push_data.idx = idx_s1;
		push_data.ox  = ox_s1;
		push_data.oy  = oy_s1;
	end

endmodule

// ===== rtl/cbtd_queue.sv =====
// Short queue of classified subblocks between front and back.
// Depends on cbtd_pkg for the entry type and depth.
module cbtd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  cbtd_pkg::cbtd_entry_t push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output cbtd_pkg::cbtd_entry_t pop_data
);
	import cbtd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cbtd_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/cbtd_back.sv =====
// Back end: walks the four rows of the queued subblock, picks palette
// colors, clips against the image and holds each row in an output register.
// Depends on cbtd_pkg.
module cbtd_back #(
	parameter int MAX_DIMENSION = cbtd_pkg::MAX_DIMENSION_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [cbtd_pkg::DIM_W-1:0]     image_width,
	input  logic [cbtd_pkg::DIM_W-1:0]     image_height,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  cbtd_pkg::cbtd_entry_t          pop_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cbtd_pkg::ROW_W-1:0]     row_index,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_zero,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_one,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_two,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_three,
	output logic [cbtd_pkg::LANES-1:0]     valid_mask,
	output logic                           last_row
);
	import cbtd_pkg::*;

	localparam int               DIM_MAX   = (1 << DIM_W) - 1;
	localparam logic [DIM_W-1:0] DIM_CLAMP = (MAX_DIMENSION > DIM_MAX) ?
		DIM_W'(DIM_MAX) : DIM_W'(MAX_DIMENSION);
	localparam int               SUM_W     = DIM_W + 1;

	logic [ROW_W-1:0]              row_q;
	logic                          out_v_q;
	logic [ROW_W-1:0]              row_index_q;
	logic [LANES-1:0][TEXEL_W-1:0] texel_q;
	logic [LANES-1:0]              mask_q;
	logic                          last_q;

	logic                          load;
	logic [DIM_W-1:0]              w_eff;
	logic [DIM_W-1:0]              h_eff;
	logic [LANES-1:0][TEXEL_W-1:0] texel_d;
	logic [LANES-1:0]              mask_d;

	assign load      = pop_valid && (!out_v_q || out_ready);
	assign pop_ready = load && (row_q == ROW_LAST);
	assign w_eff     = (image_width > DIM_CLAMP) ? DIM_CLAMP : image_width;
	assign h_eff     = (image_height > DIM_CLAMP) ? DIM_CLAMP : image_height;

	// Row decode: index byte, palette select and bounds check per lane
	always_comb begin
		logic [7:0]       row_bits;
		logic [1:0]       sel;
		logic             row_in;
		logic [SUM_W-1:0] col;
		row_bits = pop_data.idx[(ROW_LAST - row_q) * 8 +: 8];
		row_in   = ({{(SUM_W-COORD_W){1'b0}}, pop_data.oy} +
			{{(SUM_W-ROW_W){1'b0}}, row_q}) < {1'b0, h_eff};
		for (int k = 0; k < LANES; k++) begin
			sel        = row_bits[(LANES - 1 - k) * 2 +: 2];
			col        = {{(SUM_W-COORD_W){1'b0}}, pop_data.ox} + SUM_W'(k);
			mask_d[k]  = row_in && (col < {1'b0, w_eff});
			texel_d[k] = mask_d[k] ? pop_data.pal[sel] : '0;
		end
	end

	// Row counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				row_q <= row_q + 1'b1;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output row register
	always_ff @(posedge clk) begin
		if (load) begin
			row_index_q <= row_q;
			texel_q     <= texel_d;
			mask_q      <= mask_d;
			last_q      <= row_q == ROW_LAST;
		end
	end

	assign out_valid   = out_v_q;
	assign row_index   = row_index_q;
	assign texel_zero  = texel_q[0];
	assign texel_one   = texel_q[1];
	assign texel_two   = texel_q[2];
	assign texel_three = texel_q[3];
	assign valid_mask  = mask_q;
	assign last_row    = last_q;

	// A subblock leaves the queue only after its last row
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |-> row_q == ROW_LAST)
		else $error("subblock popped before its last row");

	// Row tag and last flag agree on every beat
	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (last_q == (row_index_q == ROW_LAST)))
		else $error("last_row does not match row_index");

	// Clipped lane 0 carries zero
	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !mask_q[0]) |-> texel_q[0] == '0)
		else $error("clipped texel not zero");

	// Output row tag matches the row counter on each loaded beat
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> row_index_q == $past(row_q))
		else $error("row sequence broken");

endmodule

// ===== rtl/cmpr_block_texture_decoder_top.sv =====
// Top level of the compressed block texture decoder: APB register file,
// front end, subblock queue and row back end. Depends on cbtd_pkg and all cbtd_ modules.
//
// Each accepted subblock beat (two RGB565 endpoints, 32 index bits and a texel
// origin) yields four output beats, rows 0 to 3 in order, each with four RGBA8
// texels, a lane valid mask that clips against image_width / image_height
// (register 0 at byte 0, register 1 at byte 4, 11 bits each, reset 1024, values
// above MAX_DIMENSION act as MAX_DIMENSION), and a last_row flag. The back
// end's row counter emits one row per cycle unless the queue is empty or
// out_ready is low; the front end keeps accepting into a two-entry queue while
// rows drain. Rows pass the front stage, queue and output registers. Clipped
// texels read as zero. Write registers only while the block is idle.
module cmpr_block_texture_decoder_top #(
	parameter int MAX_DIMENSION = cbtd_pkg::MAX_DIMENSION_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cbtd_pkg::COLOR_W-1:0]   color_first,
	input  logic [cbtd_pkg::COLOR_W-1:0]   color_second,
	input  logic [cbtd_pkg::INDEX_W-1:0]   index_bits,
	input  logic [cbtd_pkg::COORD_W-1:0]   origin_x,
	input  logic [cbtd_pkg::COORD_W-1:0]   origin_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cbtd_pkg::ROW_W-1:0]     row_index,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_zero,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_one,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_two,
	output logic [cbtd_pkg::TEXEL_W-1:0]   texel_three,
	output logic [cbtd_pkg::LANES-1:0]     valid_mask,
	output logic                           last_row
);
	import cbtd_pkg::*;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;
	cbtd_hs_t         push_hs;
	cbtd_hs_t         pop_hs;
	cbtd_entry_t      push_data;
	cbtd_entry_t      pop_data;

	// Register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	cbtd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.color_first  (color_first),
		.color_second (color_second),
		.index_bits   (index_bits),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.push_valid   (push_hs.valid),
		.push_ready   (push_hs.ready),
		.push_data    (push_data)
	);

	cbtd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_hs.valid),
		.push_ready (push_hs.ready),
		.push_data  (push_data),
		.pop_valid  (pop_hs.valid),
		.pop_ready  (pop_hs.ready),
		.pop_data   (pop_data)
	);

	cbtd_back #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.pop_valid    (pop_hs.valid),
		.pop_ready    (pop_hs.ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_index    (row_index),
		.texel_zero   (texel_zero),
		.texel_one    (texel_one),
		.texel_two    (texel_two),
		.texel_three  (texel_three),
		.valid_mask   (valid_mask),
		.last_row     (last_row)
	);

endmodule
